@@ rtl/rmq_pkg.sv @@
// Shared types, widths and codes for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;
    localparam int OUT_W     = 18;

    // signed width of trace/radicand sums
    localparam int RAD_W     = (FRAC_BITS + 2 > IN_W + 3) ? FRAC_BITS + 2 : IN_W + 3;
    localparam int SQ_IN_W   = RAD_W + FRAC_BITS;
    localparam int ROOT_W    = (SQ_IN_W + 1) / 2;
    localparam int SQ_PAD_W  = 2 * ROOT_W;
    localparam int SQ_REM_W  = ROOT_W + 2;

    // numerator magnitude, divisor (2r), dividend and divider remainder
    localparam int NUM_W     = IN_W + 1;
    localparam int MAG_W     = IN_W + 1;
    localparam int DIV_W     = ROOT_W + 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS + 1;
    localparam int DREM_W    = DIV_W + 1;

    localparam logic [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic             valid;
        logic             invalid;
        branch_t          branch;
        logic [2:0]       sign;
        mag_t [2:0]       mag;
    } sq_ctx_t;

    typedef struct packed {
        logic [SQ_PAD_W-1:0] rad;
        logic [ROOT_W-1:0]   root;
        logic [SQ_REM_W-1:0] rem;
    } sq_state_t;

    typedef struct packed {
        logic             valid;
        logic             invalid;
        branch_t          branch;
        logic [OUT_W-1:0] half;
        logic [2:0]       sign;
        logic [DIV_W-1:0] dsr;
    } dv_ctx_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [DVD_W-1:0]  dvd;
    } dv_lane_t;

    typedef dv_lane_t [2:0] dv_lanes_t;

endpackage

@@ rtl/rotation_matrix_to_quaternion_unit.sv @@
// Top level: rotation matrix to quaternion converter, fully pipelined.
//
// Input channel: item_valid / item_stall carry the nine matrix entries
// m00..m22 (signed Q2.16). A transfer happens on a rising edge with
// item_valid high and item_stall low.
// Output channel: quat_valid / quat_stall carry qx, qy, qz, qw (signed
// Q2.16, saturated) and invalid. Same transfer rule.
// Throughput: one matrix per cycle while no result is held on quat_stall.
// Path: entry stage, root chain (one cell per root bit), handoff register,
// divider chain (one cell per dividend bit), output register.
// All stages advance together. While a result waits on quat_stall, the
// whole chain holds, bubbles included, and item_stall is raised until
// the held result transfers.
// Reset clears every valid bit; the block then takes items at once.
// invalid = 1 when the chosen radicand is not positive, with all
// four components zero.
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic signed [IN_W-1:0]  m00,
    input  logic signed [IN_W-1:0]  m01,
    input  logic signed [IN_W-1:0]  m02,
    input  logic signed [IN_W-1:0]  m10,
    input  logic signed [IN_W-1:0]  m11,
    input  logic signed [IN_W-1:0]  m12,
    input  logic signed [IN_W-1:0]  m20,
    input  logic signed [IN_W-1:0]  m21,
    input  logic signed [IN_W-1:0]  m22,
    output logic                    quat_valid,
    input  logic                    quat_stall,
    output logic signed [OUT_W-1:0] qx,
    output logic signed [OUT_W-1:0] qy,
    output logic signed [OUT_W-1:0] qz,
    output logic signed [OUT_W-1:0] qw,
    output logic                    invalid
);

    logic adv;

    sq_ctx_t   sq_ctx [ROOT_W+1];
    sq_state_t sq_st  [ROOT_W+1];
    dv_ctx_t   dv_ctx [DVD_W+1];
    dv_lanes_t dv_lane[DVD_W+1];

    // global advance: move unless a finished result is held
    assign adv        = !quat_valid || !quat_stall;
    assign item_stall = !adv;

    rmq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .load    (item_valid),
        .m00     (m00), .m01 (m01), .m02 (m02),
        .m10     (m10), .m11 (m11), .m12 (m12),
        .m20     (m20), .m21 (m21), .m22 (m22),
        .ctx_out (sq_ctx[0]),
        .st_out  (sq_st[0])
    );

    // root chain: one root bit per cell
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctx_in  (sq_ctx[g]),
            .st_in   (sq_st[g]),
            .ctx_out (sq_ctx[g+1]),
            .st_out  (sq_st[g+1])
        );
    end

    // handoff: r -> divisor 2r, major term r/2, dividends mag*2^F + r
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-2:0] root_half;
    dv_ctx_t           hand_ctx_reg, hand_ctx_next;
    dv_lanes_t         hand_lane_reg, hand_lane_next;

    always_comb
    begin
        root      = sq_st[ROOT_W].root;
        root_half = root[ROOT_W-1:1];
        hand_ctx_next.valid   = sq_ctx[ROOT_W].valid;
        hand_ctx_next.invalid = sq_ctx[ROOT_W].invalid;
        hand_ctx_next.branch  = sq_ctx[ROOT_W].branch;
        hand_ctx_next.sign    = sq_ctx[ROOT_W].sign;
        hand_ctx_next.dsr     = {root, 1'b0};
        hand_ctx_next.half    = (ROOT_W'(root_half) > ROOT_W'(Q_MAX)) ? Q_MAX
                                : OUT_W'(root_half);
        for (int k = 0; k < 3; k++)
        begin
            hand_lane_next[k].rem = '0;
            hand_lane_next[k].dvd = (DVD_W'(sq_ctx[ROOT_W].mag[k]) << FRAC_BITS)
                                    + DVD_W'(root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_ctx_reg  <= '0;
            hand_lane_reg <= '0;
        end
        else if (adv)
        begin
            hand_ctx_reg  <= hand_ctx_next;
            hand_lane_reg <= hand_lane_next;
        end
    end

    assign dv_ctx[0]  = hand_ctx_reg;
    assign dv_lane[0] = hand_lane_reg;

    // divider chain: one quotient bit per cell, three lanes side by side
    for (genvar g = 0; g < DVD_W; g++)
    begin : g_div
        rmq_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctx_in   (dv_ctx[g]),
            .lane_in  (dv_lane[g]),
            .ctx_out  (dv_ctx[g+1]),
            .lane_out (dv_lane[g+1])
        );
    end

    // output stage: saturate, apply sign, place major term by branch, zero all on invalid
    logic [DVD_W-1:0]        lim     [3];
    logic [OUT_W-1:0]        mag_sat [3];
    logic signed [OUT_W-1:0] minor   [3];
    logic signed [OUT_W-1:0] slot    [4];
    logic signed [OUT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic                    valid_reg, invalid_reg;
    logic signed [OUT_W-1:0] half_s;
    dv_ctx_t                 fin;

    always_comb
    begin
        fin    = dv_ctx[DVD_W];
        half_s = signed'(fin.half);
        for (int k = 0; k < 3; k++)
        begin
            // negative side saturates one step further, to the most negative code
            lim[k]     = DVD_W'(Q_MAX) + DVD_W'(fin.sign[k]);
            mag_sat[k] = (dv_lane[DVD_W][k].dvd > lim[k]) ? lim[k][OUT_W-1:0]
                         : dv_lane[DVD_W][k].dvd[OUT_W-1:0];
            minor[k]   = fin.sign[k] ? -signed'(mag_sat[k]) : signed'(mag_sat[k]);
        end
        case (fin.branch)
            BR_TRACE:
            begin
                slot[0] = minor[0]; slot[1] = minor[1];
                slot[2] = minor[2]; slot[3] = half_s;
            end
            BR_X:
            begin
                slot[0] = half_s;   slot[1] = minor[0];
                slot[2] = minor[1]; slot[3] = minor[2];
            end
            BR_Y:
            begin
                slot[0] = minor[0]; slot[1] = half_s;
                slot[2] = minor[1]; slot[3] = minor[2];
            end
            default:
            begin
                slot[0] = minor[0]; slot[1] = minor[1];
                slot[2] = half_s;   slot[3] = minor[2];
            end
        endcase
        if (fin.invalid)
        begin
            for (int k = 0; k < 4; k++)
            begin
                slot[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg      <= slot[0];
            qy_reg      <= slot[1];
            qz_reg      <= slot[2];
            qw_reg      <= slot[3];
            invalid_reg <= fin.invalid;
        end
    end

    assign quat_valid = valid_reg;
    assign qx         = qx_reg;
    assign qy         = qy_reg;
    assign qz         = qz_reg;
    assign qw         = qw_reg;
    assign invalid    = invalid_reg;

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && invalid |-> (qx == '0) && (qy == '0) && (qz == '0) && (qw == '0))
        else $error("invalid result with nonzero component");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |-> item_stall)
        else $error("input taken while output held");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_ctx[ROOT_W].valid && !sq_ctx[ROOT_W].invalid |-> root != '0)
        else $error("zero root on a valid radicand");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> quat_valid && $stable(qx) && $stable(invalid))
        else $error("held result changed");
`endif

endmodule

@@ rtl/rmq_front.sv @@
// Entry stage: branch choice, radicand and the three minor numerators.
module rmq_front
    import rmq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   load,
    input  logic signed [IN_W-1:0] m00,
    input  logic signed [IN_W-1:0] m01,
    input  logic signed [IN_W-1:0] m02,
    input  logic signed [IN_W-1:0] m10,
    input  logic signed [IN_W-1:0] m11,
    input  logic signed [IN_W-1:0] m12,
    input  logic signed [IN_W-1:0] m20,
    input  logic signed [IN_W-1:0] m21,
    input  logic signed [IN_W-1:0] m22,
    output sq_ctx_t                ctx_out,
    output sq_state_t              st_out
);

    localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) <<< FRAC_BITS;

    logic signed [RAD_W-1:0] e00, e11, e22;
    logic signed [RAD_W-1:0] trace, rad_t, rad_x, rad_y, rad_z, rad;
    logic signed [NUM_W-1:0] n_21_12, n_02_20, n_10_01, n_01_10, n_20_02, n_12_21;
    logic signed [NUM_W-1:0] num [3];
    branch_t                 branch;
    logic                    bad;
    sq_ctx_t                 ctx_reg, ctx_next;
    sq_state_t               st_reg, st_next;

    always_comb
    begin
        e00     = RAD_W'(m00);
        e11     = RAD_W'(m11);
        e22     = RAD_W'(m22);
        trace   = e00 + e11 + e22;
        rad_t   = trace + ONE;
        rad_x   = e00 - e11 - e22 + ONE;
        rad_y   = e11 - e22 - e00 + ONE;
        rad_z   = e22 - e00 - e11 + ONE;
        n_21_12 = NUM_W'(m21) - NUM_W'(m12);
        n_02_20 = NUM_W'(m02) - NUM_W'(m20);
        n_10_01 = NUM_W'(m10) - NUM_W'(m01);
        n_01_10 = NUM_W'(m01) + NUM_W'(m10);
        n_20_02 = NUM_W'(m20) + NUM_W'(m02);
        n_12_21 = NUM_W'(m12) + NUM_W'(m21);

        if (!trace[RAD_W-1])
        begin
            branch = BR_TRACE;
        end
        else if (m11 > m00)
        begin
            branch = (m22 > m11) ? BR_Z : BR_Y;
        end
        else if (m22 > m00)
        begin
            branch = BR_Z;
        end
        else
        begin
            branch = BR_X;
        end

        // minor lanes in slot order, major slot skipped
        case (branch)
            BR_TRACE:
            begin
                rad = rad_t;
                num[0] = n_21_12; num[1] = n_02_20; num[2] = n_10_01;
            end
            BR_X:
            begin
                rad = rad_x;
                num[0] = n_01_10; num[1] = n_20_02; num[2] = n_21_12;
            end
            BR_Y:
            begin
                rad = rad_y;
                num[0] = n_01_10; num[1] = n_12_21; num[2] = n_02_20;
            end
            default:
            begin
                rad = rad_z;
                num[0] = n_20_02; num[1] = n_12_21; num[2] = n_10_01;
            end
        endcase

        bad = rad[RAD_W-1] || (rad == '0);

        ctx_next.valid   = load;
        ctx_next.invalid = bad;
        ctx_next.branch  = branch;
        for (int k = 0; k < 3; k++)
        begin
            ctx_next.sign[k] = num[k][NUM_W-1];
            ctx_next.mag[k]  = num[k][NUM_W-1] ? MAG_W'(-num[k]) : MAG_W'(num[k]);
        end

        st_next.rad  = bad ? '0 : (SQ_PAD_W'(unsigned'(rad)) << FRAC_BITS);
        st_next.root = '0;
        st_next.rem  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '0;
            st_reg  <= '0;
        end
        else if (en)
        begin
            ctx_reg <= ctx_next;
            st_reg  <= st_next;
        end
    end

    assign ctx_out = ctx_reg;
    assign st_out  = st_reg;

endmodule

@@ rtl/rmq_sqrt_cell.sv @@
// One square root cell: retires one root bit per stage.
module rmq_sqrt_cell
    import rmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  sq_ctx_t   ctx_in,
    input  sq_state_t st_in,
    output sq_ctx_t   ctx_out,
    output sq_state_t st_out
);

    logic [SQ_REM_W-1:0] rem_sh, trial;
    logic                ge;
    sq_ctx_t             ctx_reg;
    sq_state_t           st_reg, st_next;

    always_comb
    begin
        rem_sh       = {st_in.rem[SQ_REM_W-3:0], st_in.rad[SQ_PAD_W-1 -: 2]};
        trial        = {st_in.root, 2'b01};
        ge           = rem_sh >= trial;
        st_next.rem  = ge ? rem_sh - trial : rem_sh;
        st_next.root = {st_in.root[ROOT_W-2:0], ge};
        st_next.rad  = {st_in.rad[SQ_PAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '0;
            st_reg  <= '0;
        end
        else if (en)
        begin
            ctx_reg <= ctx_in;
            st_reg  <= st_next;
        end
    end

    assign ctx_out = ctx_reg;
    assign st_out  = st_reg;

endmodule

@@ rtl/rmq_div_cell.sv @@
// One divider cell: one quotient bit per stage for all three minor lanes.
module rmq_div_cell
    import rmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  dv_ctx_t   ctx_in,
    input  dv_lanes_t lane_in,
    output dv_ctx_t   ctx_out,
    output dv_lanes_t lane_out
);

    logic [DREM_W-1:0] tmp [3];
    logic [DREM_W-1:0] dsr_x;
    logic [2:0]        ge;
    dv_ctx_t           ctx_reg;
    dv_lanes_t         lane_reg, lane_next;

    always_comb
    begin
        dsr_x = {1'b0, ctx_in.dsr};
        for (int k = 0; k < 3; k++)
        begin
            tmp[k] = {lane_in[k].rem[DREM_W-2:0], lane_in[k].dvd[DVD_W-1]};
            ge[k]  = tmp[k] >= dsr_x;
            lane_next[k].rem = ge[k] ? tmp[k] - dsr_x : tmp[k];
            lane_next[k].dvd = {lane_in[k].dvd[DVD_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg  <= '0;
            lane_reg <= '0;
        end
        else if (en)
        begin
            ctx_reg  <= ctx_in;
            lane_reg <= lane_next;
        end
    end

    assign ctx_out  = ctx_reg;
    assign lane_out = lane_reg;

endmodule
